/* rtl/core/ces_pkg.sv */
// ----------------------------------------------------------------------------
// ces_pkg
// Shared types and codes for the calculator entry stack: command codes,
// datapath operations, status codes and the control/status structs.
// ----------------------------------------------------------------------------
package ces_pkg;

  localparam int unsigned OperandW = 32;
  localparam int unsigned CountW   = 4;

  typedef enum logic [2:0] {
    CMD_DIGIT = 3'd0,
    CMD_PUSH  = 3'd1,
    CMD_POP   = 3'd2,
    CMD_REPL  = 3'd3,
    CMD_SWAP  = 3'd4,
    CMD_CLEAR = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_DIGIT = 3'd1,
    OP_PUSH  = 3'd2,
    OP_POP   = 3'd3,
    OP_REPL  = 3'd4,
    OP_SWAP  = 3'd5,
    OP_CLEAR = 3'd6
  } stack_op_e;

  // controller -> datapath
  typedef struct packed {
    logic      load;    // capture command and operand
    logic      exec;    // apply op to the stack, register result
    stack_op_e op;
    status_e   status;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       empty;
    logic       full;
    logic       lt2;
  } dp_stat_t;

endpackage

/* rtl/core/calculator_entry_stack.sv */
// ----------------------------------------------------------------------------
// calculator_entry_stack
// Operand stack of a reverse-Polish calculator: digit entry, push, pop,
// replace, swap and clear, one result per command.
// ----------------------------------------------------------------------------
// Usage:
//   A command (cmd_i, operand_i) transfers in at a rising edge where start
//   is high and busy is low. busy is high in the cycle after that,
//   while the stack is updated; the result then shows for exactly one cycle
//   with valid_o high, and start may already be taken in that same cycle.
//   On transfer the command and operand are captured; while busy the
//   operation is applied to the entry registers and no new command is taken
//   (top kept in slot 0, so every command is a single parallel shift or
//   rewrite, with the x10 digit step in the same cycle).
//   The receiver cannot stall; a result not taken in its strobe cycle is
//   gone. entry_count_o carries the low four bits of the occupancy.
//   Reset empties the stack and zeroes every entry at once; a command may be
//   issued in the first cycle after reset is released.
// ----------------------------------------------------------------------------
module calculator_entry_stack #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          cmd_i,
  input  logic signed [31:0]  operand_i,
  output logic                valid_o,
  output logic signed [31:0]  top_value_o,
  output logic signed [31:0]  popped_value_o,
  output logic [3:0]          entry_count_o,
  output logic                is_empty_o,
  output logic                is_full_o,
  output logic [1:0]          status_o
);
  import ces_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;

  ces_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .valid_o (valid_o),
    .stat_i  (stat),
    .ctl_o   (ctl)
  );

  ces_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .operand_i      (operand_i),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .top_value_o    (top_value_o),
    .popped_value_o (popped_value_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o),
    .status_o       (status_o)
  );

endmodule

/* rtl/core/ces_ctrl.sv */
// ----------------------------------------------------------------------------
// ces_ctrl
// Command sequencer: takes a transfer in, decodes it against the stack
// occupancy and issues one datapath operation, then strobes the result.
// ----------------------------------------------------------------------------
module ces_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  output logic            valid_o,
  input  ces_pkg::dp_stat_t stat_i,
  output ces_pkg::ctl_cmd_t ctl_o
);
  import ces_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   valid_q, valid_d;
  cmd_e   cmd;

  assign cmd = cmd_e'(stat_i.cmd);

  always_comb begin
    state_d = state_q;
    valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
        valid_d = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // decode against occupancy; a failed command leaves the stack alone
  always_comb begin
    ctl_o.load   = (state_q == S_IDLE) && start;
    ctl_o.exec   = (state_q == S_EXEC);
    ctl_o.op     = OP_NONE;
    ctl_o.status = ST_OK;
    case (cmd)
      CMD_DIGIT: ctl_o.op = OP_DIGIT;
      CMD_PUSH: begin
        if (stat_i.full) ctl_o.status = ST_OVER;
        else             ctl_o.op     = OP_PUSH;
      end
      CMD_POP: begin
        if (stat_i.empty) ctl_o.status = ST_UNDER;
        else              ctl_o.op     = OP_POP;
      end
      CMD_REPL: begin
        if (stat_i.empty) ctl_o.status = ST_UNDER;
        else              ctl_o.op     = OP_REPL;
      end
      CMD_SWAP: begin
        if (stat_i.lt2) ctl_o.status = ST_UNDER;
        else            ctl_o.op     = OP_SWAP;
      end
      CMD_CLEAR: begin
        if (!stat_i.empty) ctl_o.op = OP_CLEAR;
      end
      default: ctl_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign busy    = (state_q == S_EXEC);
  assign valid_o = valid_q;

endmodule

/* rtl/core/ces_dp.sv */
// ----------------------------------------------------------------------------
// ces_dp
// Stack datapath: a shift-line of entries with the top at slot 0, the
// occupancy counter, the digit accumulator and the result registers.
// ----------------------------------------------------------------------------
module ces_dp #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [2:0]                   cmd_i,
  input  logic signed [31:0]           operand_i,
  input  ces_pkg::ctl_cmd_t            ctl_i,
  output ces_pkg::dp_stat_t            stat_o,
  output logic signed [31:0]           top_value_o,
  output logic signed [31:0]           popped_value_o,
  output logic [3:0]                   entry_count_o,
  output logic                         is_empty_o,
  output logic                         is_full_o,
  output logic [1:0]                   status_o
);
  import ces_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // slots at or beyond the count always hold zero
  logic [OperandW-1:0] ent_q [DEPTH];
  logic [OperandW-1:0] ent_d [DEPTH];
  logic [CntW-1:0]     count_q, count_d;
  logic [2:0]          cmd_q;
  logic [OperandW-1:0] opnd_q;
  logic [OperandW-1:0] popped_q, popped_d;
  status_e             status_q;
  logic [OperandW-1:0] digit_sum;

  assign digit_sum = (ent_q[0] << 3) + (ent_q[0] << 1) + opnd_q;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) ent_d[i] = ent_q[i];
    count_d  = count_q;
    popped_d = '0;
    case (ctl_i.op)
      OP_DIGIT: begin
        ent_d[0] = digit_sum;
        if (count_q == '0) count_d = CntW'(1);
      end
      OP_PUSH: begin
        for (int i = 1; i < DEPTH; i++) ent_d[i] = ent_q[i-1];
        ent_d[0] = '0;
        count_d  = count_q + CntW'(1);
      end
      OP_POP: begin
        popped_d = ent_q[0];
        for (int i = 0; i < DEPTH - 1; i++) ent_d[i] = ent_q[i+1];
        ent_d[DEPTH-1] = '0;
        count_d        = count_q - CntW'(1);
      end
      OP_REPL: ent_d[0] = opnd_q;
      OP_SWAP: begin
        ent_d[0] = ent_q[1];
        ent_d[1] = ent_q[0];
      end
      OP_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) ent_d[i] = '0;
        count_d = CntW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) ent_q[i] <= '0;
      count_q  <= '0;
      popped_q <= '0;
      status_q <= ST_OK;
    end else if (ctl_i.exec) begin
      for (int i = 0; i < DEPTH; i++) ent_q[i] <= ent_d[i];
      count_q  <= count_d;
      popped_q <= popped_d;
      status_q <= ctl_i.status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= cmd_i;
      opnd_q <= operand_i;
    end
  end

  assign stat_o.cmd   = cmd_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(DEPTH));
  assign stat_o.lt2   = (count_q < CntW'(2));

  assign top_value_o    = ent_q[0];
  assign popped_value_o = popped_q;
  assign entry_count_o  = CountW'(count_q);
  assign is_empty_o     = stat_o.empty;
  assign is_full_o      = stat_o.full;
  assign status_o       = status_q;

endmodule
